// ===== sv/atsub_pkg.sv =====
// ----------------------------------------------------------------------------
// atsub_pkg
// shared types, codes and sizes of the adaptive triangle subdivider
// ----------------------------------------------------------------------------
package atsub_pkg;

  localparam int NODES     = 1024;
  localparam int IDX_W     = 10;
  localparam int CNT_W     = 11;
  localparam int CW        = 24;
  localparam int CFG_W     = 23;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_AREA    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_DEPTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WALL_MARGIN = 3'd4;

  localparam logic [CFG_W-1:0] RST_MAX_AREA    = 23'd3277;
  localparam logic [CFG_W-1:0] RST_HALF_WIDTH  = 23'd262144;
  localparam logic [CFG_W-1:0] RST_HALF_HEIGHT = 23'd196608;
  localparam logic [CFG_W-1:0] RST_HALF_DEPTH  = 23'd327680;
  localparam logic [CFG_W-1:0] RST_WALL_MARGIN = 23'd13107;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_UNWRITTEN = 2'd2;

  typedef enum logic [1:0] {
    FN_APPEND = 2'd0,
    FN_REFINE = 2'd1,
    FN_READ   = 2'd2,
    FN_CLEAR  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    OP_APPEND,
    OP_REFINE,
    OP_READ,
    OP_CLEAR
  } op_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_RDN,
    B_RDB,
    B_RDC,
    B_LATC,
    B_DIFF,
    B_MUL,
    B_DECIDE,
    B_WR,
    B_EMIT
  } bstate_e;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } vec_t;

  typedef struct packed {
    vec_t pos;
    vec_t vel;
  } node_t;

  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] c;
    node_t            node;
  } cmd_t;

  typedef struct packed {
    logic [CFG_W-1:0] max_area;
    logic [CFG_W-1:0] half_width;
    logic [CFG_W-1:0] half_height;
    logic [CFG_W-1:0] half_depth;
    logic [CFG_W-1:0] wall_margin;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] ta;
    logic [IDX_W-1:0] tb;
    logic [IDX_W-1:0] tc;
    logic             split;
    node_t            node;
    logic             last;
  } res_t;

endpackage

// ===== sv/atsub_if.sv =====
// ----------------------------------------------------------------------------
// atsub_if
// request and result channels of the adaptive triangle subdivider
// ----------------------------------------------------------------------------
interface atsub_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic [9:0]        vertex_a;
  logic [9:0]        vertex_b;
  logic [9:0]        vertex_c;
  logic signed [23:0] in_pos_x;
  logic signed [23:0] in_pos_y;
  logic signed [23:0] in_pos_z;
  logic signed [23:0] in_vel_x;
  logic signed [23:0] in_vel_y;
  logic signed [23:0] in_vel_z;

  modport source (output valid, func, vertex_a, vertex_b, vertex_c, in_pos_x, in_pos_y,
                  in_pos_z, in_vel_x, in_vel_y, in_vel_z, input ready);
  modport sink (input valid, func, vertex_a, vertex_b, vertex_c, in_pos_x, in_pos_y,
                in_pos_z, in_vel_x, in_vel_y, in_vel_z, output ready);
endinterface

interface atsub_out_if;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [9:0]        out_tri_a;
  logic [9:0]        out_tri_b;
  logic [9:0]        out_tri_c;
  logic              was_split;
  logic signed [23:0] out_pos_x;
  logic signed [23:0] out_pos_y;
  logic signed [23:0] out_pos_z;
  logic signed [23:0] out_vel_x;
  logic signed [23:0] out_vel_y;
  logic signed [23:0] out_vel_z;
  logic              last;

  modport source (output valid, status, out_tri_a, out_tri_b, out_tri_c, was_split,
                  out_pos_x, out_pos_y, out_pos_z, out_vel_x, out_vel_y, out_vel_z, last,
                  input ready);
  modport sink (input valid, status, out_tri_a, out_tri_b, out_tri_c, was_split,
                out_pos_x, out_pos_y, out_pos_z, out_vel_x, out_vel_y, out_vel_z, last,
                output ready);
endinterface

// ===== sv/atsub_front.sv =====
// ----------------------------------------------------------------------------
// atsub_front
// accepts requests, decodes the function and queues them for the back end
// ----------------------------------------------------------------------------
module atsub_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  atsub_in_if.sink       in_ch,
  output logic           cmd_valid_o,
  output atsub_pkg::cmd_t cmd_o,
  input  logic           cmd_pop_i
);
  import atsub_pkg::*;

  cmd_t       fifo_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       push;
  cmd_t       cmd_new;

  always_comb begin
    unique case (func_e'(in_ch.func))
      FN_APPEND: cmd_new.op = OP_APPEND;
      FN_REFINE: cmd_new.op = OP_REFINE;
      FN_READ:   cmd_new.op = OP_READ;
      FN_CLEAR:  cmd_new.op = OP_CLEAR;
      default:   cmd_new.op = OP_CLEAR;
    endcase
    cmd_new.a          = in_ch.vertex_a;
    cmd_new.b          = in_ch.vertex_b;
    cmd_new.c          = in_ch.vertex_c;
    cmd_new.node.pos.x = in_ch.in_pos_x;
    cmd_new.node.pos.y = in_ch.in_pos_y;
    cmd_new.node.pos.z = in_ch.in_pos_z;
    cmd_new.node.vel.x = in_ch.in_vel_x;
    cmd_new.node.vel.y = in_ch.in_vel_y;
    cmd_new.node.vel.z = in_ch.in_vel_z;
  end

  assign in_ch.ready = (cnt_q != 2'd2);
  assign push        = in_ch.valid && in_ch.ready;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wp_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) begin
        wp_q <= ~wp_q;
      end
      if (cmd_pop_i) begin
        rp_q <= ~rp_q;
      end
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_pop_i};
    end
  end

endmodule

// ===== sv/atsub_back.sv =====
// ----------------------------------------------------------------------------
// atsub_back
// node store, area test on a shared multiplier, midpoint writes and results
// ----------------------------------------------------------------------------
module atsub_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  input  atsub_pkg::cmd_t cmd_i,
  output logic            cmd_pop_o,
  input  atsub_pkg::cfg_t cfg_i,
  output logic            res_valid_o,
  output atsub_pkg::res_t res_o,
  input  logic            res_ready_i
);
  import atsub_pkg::*;

  bstate_e          state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  node_t            mem [NODES];
  logic             re, we;
  logic [IDX_W-1:0] raddr, waddr;
  node_t            wdata;
  node_t            rd_q;

  logic [IDX_W-1:0] a_q, b_q, c_q, base_q;
  node_t            pa_q, pb_q, pc_q;
  logic             near_q;
  logic signed [CW:0] ux_q, uy_q, uz_q, vx_q, vy_q, vz_q;

  logic [4:0]         ms_q;
  logic [4:0]         tag;
  logic signed [25:0] ma, mb;
  logic signed [51:0] p_q, pr_q;
  logic [49:0]        cx_q, cy_q, cz_q;
  logic [101:0]       sum_q;
  logic [79:0]        tt_q;
  logic [101:0]       term;

  logic [1:0] wk_q, ek_q;
  logic       ov_q;
  res_t       ores_q, res_d;
  logic       res_load, out_free;
  logic       bad_idx, big, split;

  function automatic logic near_wall(vec_t p, cfg_t c);
    logic signed [CW:0] lx, ly, lz;
    logic [CW-1:0]      mx, my, mz;
    lx = $signed({2'b00, c.half_width})  - $signed({2'b00, c.wall_margin});
    ly = $signed({2'b00, c.half_height}) - $signed({2'b00, c.wall_margin});
    lz = $signed({2'b00, c.half_depth})  - $signed({2'b00, c.wall_margin});
    mx = p.x[CW-1] ? (~p.x + CW'(1)) : p.x;
    my = p.y[CW-1] ? (~p.y + CW'(1)) : p.y;
    mz = p.z[CW-1] ? (~p.z + CW'(1)) : p.z;
    return ($signed({1'b0, mx}) > lx) || ($signed({1'b0, my}) > ly) ||
           ($signed({1'b0, mz}) > lz);
  endfunction

  function automatic logic signed [CW-1:0] avg(logic signed [CW-1:0] p,
                                               logic signed [CW-1:0] q);
    logic signed [CW:0] s;
    s = {p[CW-1], p} + {q[CW-1], q};
    return s[CW:1];
  endfunction

  function automatic node_t mid(node_t p, node_t q);
    node_t r;
    r.pos.x = avg(p.pos.x, q.pos.x);
    r.pos.y = avg(p.pos.y, q.pos.y);
    r.pos.z = avg(p.pos.z, q.pos.z);
    r.vel.x = avg(p.vel.x, q.vel.x);
    r.vel.y = avg(p.vel.y, q.vel.y);
    r.vel.z = avg(p.vel.z, q.vel.z);
    return r;
  endfunction

  function automatic logic [49:0] mag52(logic signed [51:0] v);
    logic [51:0] m;
    m = v[51] ? (~v + 52'd1) : v;
    return m[49:0];
  endfunction

  // node store
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re) begin
      rd_q <= mem[raddr];
    end
  end

  assign out_free = !ov_q || res_ready_i;
  assign bad_idx  = ({1'b0, cmd_i.a} >= cnt_q) || ({1'b0, cmd_i.b} >= cnt_q) ||
                    ({1'b0, cmd_i.c} >= cnt_q);
  assign big      = sum_q > {22'd0, tt_q};
  assign split    = big && !near_q;
  assign tag      = ms_q - 5'd1;

  // shared multiplier operands
  always_comb begin
    ma = '0;
    mb = '0;
    case (ms_q)
      5'd0:  begin ma = {uy_q[CW], uy_q}; mb = {vz_q[CW], vz_q}; end
      5'd1:  begin ma = {uz_q[CW], uz_q}; mb = {vy_q[CW], vy_q}; end
      5'd2:  begin ma = {uz_q[CW], uz_q}; mb = {vx_q[CW], vx_q}; end
      5'd3:  begin ma = {ux_q[CW], ux_q}; mb = {vz_q[CW], vz_q}; end
      5'd4:  begin ma = {ux_q[CW], ux_q}; mb = {vy_q[CW], vy_q}; end
      5'd5:  begin ma = {uy_q[CW], uy_q}; mb = {vx_q[CW], vx_q}; end
      5'd6:  begin ma = {1'b0, cx_q[49:25]}; mb = {1'b0, cx_q[49:25]}; end
      5'd7:  begin ma = {1'b0, cx_q[49:25]}; mb = {1'b0, cx_q[24:0]}; end
      5'd8:  begin ma = {1'b0, cx_q[24:0]};  mb = {1'b0, cx_q[24:0]}; end
      5'd9:  begin ma = {1'b0, cy_q[49:25]}; mb = {1'b0, cy_q[49:25]}; end
      5'd10: begin ma = {1'b0, cy_q[49:25]}; mb = {1'b0, cy_q[24:0]}; end
      5'd11: begin ma = {1'b0, cy_q[24:0]};  mb = {1'b0, cy_q[24:0]}; end
      5'd12: begin ma = {1'b0, cz_q[49:25]}; mb = {1'b0, cz_q[49:25]}; end
      5'd13: begin ma = {1'b0, cz_q[49:25]}; mb = {1'b0, cz_q[24:0]}; end
      5'd14: begin ma = {1'b0, cz_q[24:0]};  mb = {1'b0, cz_q[24:0]}; end
      5'd15: begin ma = {3'b000, cfg_i.max_area}; mb = {3'b000, cfg_i.max_area}; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_comb begin
    term = '0;
    case (tag)
      5'd6, 5'd9, 5'd12:  term = {p_q[51:0], 50'd0};
      5'd7, 5'd10, 5'd13: term = {24'd0, p_q[51:0], 26'd0};
      default:            term = {50'd0, p_q[51:0]};
    endcase
  end

  always_ff @(posedge clk_i) begin
    p_q <= ma * mb;
    if (state_q == B_DIFF) begin
      sum_q <= '0;
    end else if (state_q == B_MUL && ms_q != 5'd0) begin
      case (tag)
        5'd0, 5'd2, 5'd4: pr_q <= p_q;
        5'd1:  cx_q <= mag52(pr_q - p_q);
        5'd3:  cy_q <= mag52(pr_q - p_q);
        5'd5:  cz_q <= mag52(pr_q - p_q);
        5'd15: tt_q <= {p_q[45:0], 34'd0};
        default: sum_q <= sum_q + term;
      endcase
    end
  end

  // operand capture
  always_ff @(posedge clk_i) begin
    if (state_q == B_IDLE && cmd_pop_o) begin
      a_q <= cmd_i.a;
      b_q <= cmd_i.b;
      c_q <= cmd_i.c;
    end
    unique case (state_q)
      B_RDB: begin
        pa_q   <= rd_q;
        near_q <= near_wall(rd_q.pos, cfg_i);
      end
      B_RDC: begin
        pb_q   <= rd_q;
        near_q <= near_q | near_wall(rd_q.pos, cfg_i);
      end
      B_LATC: begin
        pc_q   <= rd_q;
        near_q <= near_q | near_wall(rd_q.pos, cfg_i);
      end
      B_DIFF: begin
        ux_q <= {pb_q.pos.x[CW-1], pb_q.pos.x} - {pa_q.pos.x[CW-1], pa_q.pos.x};
        uy_q <= {pb_q.pos.y[CW-1], pb_q.pos.y} - {pa_q.pos.y[CW-1], pa_q.pos.y};
        uz_q <= {pb_q.pos.z[CW-1], pb_q.pos.z} - {pa_q.pos.z[CW-1], pa_q.pos.z};
        vx_q <= {pc_q.pos.x[CW-1], pc_q.pos.x} - {pa_q.pos.x[CW-1], pa_q.pos.x};
        vy_q <= {pc_q.pos.y[CW-1], pc_q.pos.y} - {pa_q.pos.y[CW-1], pa_q.pos.y};
        vz_q <= {pc_q.pos.z[CW-1], pc_q.pos.z} - {pa_q.pos.z[CW-1], pa_q.pos.z};
      end
      B_DECIDE: base_q <= cnt_q[IDX_W-1:0];
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    cmd_pop_o = 1'b0;
    re        = 1'b0;
    raddr     = cmd_i.a;
    we        = 1'b0;
    waddr     = cnt_q[IDX_W-1:0];
    wdata     = cmd_i.node;
    res_load  = 1'b0;
    res_d     = '0;
    res_d.last = 1'b1;
    unique case (state_q)
      B_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.op)
            OP_APPEND: begin
              if (out_free) begin
                cmd_pop_o = 1'b1;
                res_load  = 1'b1;
                if (cnt_q >= CNT_W'(NODES)) begin
                  res_d.status = ST_FULL;
                end else begin
                  we       = 1'b1;
                  cnt_d    = cnt_q + CNT_W'(1);
                  res_d.ta = cnt_q[IDX_W-1:0];
                end
              end
            end
            OP_CLEAR: begin
              if (out_free) begin
                cmd_pop_o = 1'b1;
                res_load  = 1'b1;
                cnt_d     = '0;
              end
            end
            OP_READ: begin
              if ({1'b0, cmd_i.a} >= cnt_q) begin
                if (out_free) begin
                  cmd_pop_o    = 1'b1;
                  res_load     = 1'b1;
                  res_d.status = ST_UNWRITTEN;
                end
              end else begin
                cmd_pop_o = 1'b1;
                re        = 1'b1;
                state_d   = B_RDN;
              end
            end
            OP_REFINE: begin
              if (bad_idx) begin
                if (out_free) begin
                  cmd_pop_o    = 1'b1;
                  res_load     = 1'b1;
                  res_d.status = ST_UNWRITTEN;
                  res_d.ta     = cmd_i.a;
                  res_d.tb     = cmd_i.b;
                  res_d.tc     = cmd_i.c;
                end
              end else begin
                cmd_pop_o = 1'b1;
                re        = 1'b1;
                state_d   = B_RDB;
              end
            end
            default: ;
          endcase
        end
      end
      B_RDN: begin
        if (out_free) begin
          res_load   = 1'b1;
          res_d.ta   = a_q;
          res_d.node = rd_q;
          state_d    = B_IDLE;
        end
      end
      B_RDB: begin
        re      = 1'b1;
        raddr   = b_q;
        state_d = B_RDC;
      end
      B_RDC: begin
        re      = 1'b1;
        raddr   = c_q;
        state_d = B_LATC;
      end
      B_LATC: state_d = B_DIFF;
      B_DIFF: state_d = B_MUL;
      B_MUL: begin
        if (ms_q == 5'd16) begin
          state_d = B_DECIDE;
        end
      end
      B_DECIDE: begin
        res_d.ta = a_q;
        res_d.tb = b_q;
        res_d.tc = c_q;
        if (!split) begin
          if (out_free) begin
            res_load = 1'b1;
            state_d  = B_IDLE;
          end
        end else if ({1'b0, cnt_q} + 12'd3 > 12'(NODES)) begin
          if (out_free) begin
            res_load     = 1'b1;
            res_d.status = ST_FULL;
            state_d      = B_IDLE;
          end
        end else begin
          state_d = B_WR;
        end
      end
      B_WR: begin
        we    = 1'b1;
        waddr = base_q + IDX_W'(wk_q);
        case (wk_q)
          2'd0:    wdata = mid(pa_q, pb_q);
          2'd1:    wdata = mid(pb_q, pc_q);
          default: wdata = mid(pc_q, pa_q);
        endcase
        if (wk_q == 2'd2) begin
          cnt_d   = cnt_q + CNT_W'(3);
          state_d = B_EMIT;
        end
      end
      B_EMIT: begin
        res_d.split = 1'b1;
        res_d.last  = (ek_q == 2'd3);
        case (ek_q)
          2'd0: begin
            res_d.ta = a_q;    res_d.tb = base_q;         res_d.tc = base_q + 10'd2;
          end
          2'd1: begin
            res_d.ta = b_q;    res_d.tb = base_q + 10'd1; res_d.tc = base_q;
          end
          2'd2: begin
            res_d.ta = c_q;    res_d.tb = base_q + 10'd2; res_d.tc = base_q + 10'd1;
          end
          default: begin
            res_d.ta = base_q; res_d.tb = base_q + 10'd1; res_d.tc = base_q + 10'd2;
          end
        endcase
        if (out_free) begin
          res_load = 1'b1;
          if (ek_q == 2'd3) begin
            state_d = B_IDLE;
          end
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      cnt_q   <= '0;
      ms_q    <= '0;
      wk_q    <= '0;
      ek_q    <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (state_q == B_MUL) begin
        ms_q <= ms_q + 5'd1;
      end else begin
        ms_q <= '0;
      end
      if (state_q == B_WR) begin
        wk_q <= wk_q + 2'd1;
      end else begin
        wk_q <= '0;
      end
      if (state_q == B_EMIT) begin
        if (res_load) begin
          ek_q <= ek_q + 2'd1;
        end
      end else begin
        ek_q <= '0;
      end
      if (res_load) begin
        ov_q <= 1'b1;
      end else if (res_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      ores_q <= res_d;
    end
  end

  assign res_valid_o = ov_q;
  assign res_o       = ores_q;

endmodule

// ===== sv/adaptive_triangle_subdivider_core.sv =====
// ----------------------------------------------------------------------------
// adaptive_triangle_subdivider_core
// mesh node store with midpoint subdivision of large triangles
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  in_ch    in   valid/ready        func, vertex_a..c, in_pos_*, in_vel_*
//  out_ch   out  valid/ready        status, out_tri_a..c, was_split, out_*, last
//  cfg      in   cfg_we_i           cfg_idx_i, cfg_data_i
//
//  append, clear and failed lookups are answered from the idle state; a read
//  first fetches its node; a refine does three node reads, 16 passes through
//  the one shared 26x26 multiplier and, when split, three midpoint writes and four results
//  a two-entry request queue lets intake continue while the back end works
//  the result register holds a result under stall, reset empties queue and count
// ----------------------------------------------------------------------------
module adaptive_triangle_subdivider_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  atsub_in_if.sink                    in_ch,
  atsub_out_if.source                 out_ch,
  input  logic                        cfg_we_i,
  input  logic [atsub_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [atsub_pkg::CFG_W-1:0] cfg_data_i
);
  import atsub_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;
  logic cmd_valid, cmd_pop;
  res_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_area    <= RST_MAX_AREA;
      cfg_q.half_width  <= RST_HALF_WIDTH;
      cfg_q.half_height <= RST_HALF_HEIGHT;
      cfg_q.half_depth  <= RST_HALF_DEPTH;
      cfg_q.wall_margin <= RST_WALL_MARGIN;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAX_AREA:    cfg_q.max_area    <= cfg_data_i;
        CFG_HALF_WIDTH:  cfg_q.half_width  <= cfg_data_i;
        CFG_HALF_HEIGHT: cfg_q.half_height <= cfg_data_i;
        CFG_HALF_DEPTH:  cfg_q.half_depth  <= cfg_data_i;
        CFG_WALL_MARGIN: cfg_q.wall_margin <= cfg_data_i;
        default: ;
      endcase
    end
  end

  atsub_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  atsub_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .cfg_i       (cfg_q),
    .res_valid_o (out_ch.valid),
    .res_o       (res),
    .res_ready_i (out_ch.ready)
  );

  assign out_ch.status    = res.status;
  assign out_ch.out_tri_a = res.ta;
  assign out_ch.out_tri_b = res.tb;
  assign out_ch.out_tri_c = res.tc;
  assign out_ch.was_split = res.split;
  assign out_ch.out_pos_x = res.node.pos.x;
  assign out_ch.out_pos_y = res.node.pos.y;
  assign out_ch.out_pos_z = res.node.pos.z;
  assign out_ch.out_vel_x = res.node.vel.x;
  assign out_ch.out_vel_y = res.node.vel.y;
  assign out_ch.out_vel_z = res.node.vel.z;
  assign out_ch.last      = res.last;

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the adaptive triangle subdivider: a directed table
// and random mesh traffic under several box and area settings, every result
// compared in order against a behavioral copy of the node store
// ----------------------------------------------------------------------------
module tb_top;
  import atsub_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HOLD_LIMIT = 4000;
  localparam int DRAIN_CYC  = 40;
  localparam int BOX_R      = 163840;

  typedef struct {
    func_e            fn;
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] c;
    node_t            nd;
    bit               typed;
    res_t             want;
  } req_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  atsub_in_if  in_ch ();
  atsub_out_if out_ch ();

  adaptive_triangle_subdivider_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  node_t       mesh [NODES];
  int unsigned nodes_used;
  cfg_t        box_cfg;
  res_t        pending_q [$];
  req_t        dir_q [$];
  int          errors;
  int          idle_cycles;
  bit          hold_req;
  int          burst_left;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic longint magn(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic bit needs_split(int unsigned a, int unsigned b, int unsigned c);
    longint ux, uy, uz, vx, vy, vz, cx, cy, cz;
    logic [127:0] sum, thr;
    logic [63:0] t;
    ux = longint'(mesh[b].pos.x) - longint'(mesh[a].pos.x);
    uy = longint'(mesh[b].pos.y) - longint'(mesh[a].pos.y);
    uz = longint'(mesh[b].pos.z) - longint'(mesh[a].pos.z);
    vx = longint'(mesh[c].pos.x) - longint'(mesh[a].pos.x);
    vy = longint'(mesh[c].pos.y) - longint'(mesh[a].pos.y);
    vz = longint'(mesh[c].pos.z) - longint'(mesh[a].pos.z);
    cx = magn(uy * vz - uz * vy);
    cy = magn(uz * vx - ux * vz);
    cz = magn(ux * vy - uy * vx);
    sum = 128'(cx) * 128'(cx) + 128'(cy) * 128'(cy) + 128'(cz) * 128'(cz);
    t = (64'(box_cfg.max_area) * 2) << 16;
    thr = 128'(t) * 128'(t);
    return sum > thr;
  endfunction

  function automatic bit by_wall(int unsigned i);
    longint m;
    m = longint'(box_cfg.wall_margin);
    return magn(mesh[i].pos.x) > longint'(box_cfg.half_width) - m ||
           magn(mesh[i].pos.y) > longint'(box_cfg.half_height) - m ||
           magn(mesh[i].pos.z) > longint'(box_cfg.half_depth) - m;
  endfunction

  function automatic logic signed [CW-1:0] avg(logic signed [CW-1:0] p,
                                              logic signed [CW-1:0] q);
    longint s;
    s = longint'(p) + longint'(q);
    return CW'(s >>> 1);
  endfunction

  function automatic node_t midpoint(node_t p, node_t q);
    node_t n;
    n.pos.x = avg(p.pos.x, q.pos.x);
    n.pos.y = avg(p.pos.y, q.pos.y);
    n.pos.z = avg(p.pos.z, q.pos.z);
    n.vel.x = avg(p.vel.x, q.vel.x);
    n.vel.y = avg(p.vel.y, q.vel.y);
    n.vel.z = avg(p.vel.z, q.vel.z);
    return n;
  endfunction

  function automatic void push_tri(logic [1:0] st, int unsigned a, int unsigned b,
                                   int unsigned c, bit split, bit fin);
    res_t r;
    r = '0;
    r.status = st;
    r.ta = a[IDX_W-1:0];
    r.tb = b[IDX_W-1:0];
    r.tc = c[IDX_W-1:0];
    r.split = split;
    r.last = fin;
    pending_q = {pending_q, r};
  endfunction

  function automatic void predict_mesh(req_t q);
    res_t r;
    int unsigned ab, bc, ca;
    r = '0;
    r.last = 1'b1;
    case (q.fn)
      FN_APPEND: begin
        if (nodes_used >= NODES) begin
          r.status = ST_FULL;
        end else begin
          mesh[nodes_used] = q.nd;
          r.ta = nodes_used[IDX_W-1:0];
          nodes_used++;
        end
        pending_q = {pending_q, r};
      end
      FN_READ: begin
        if (q.a >= nodes_used) begin
          r.status = ST_UNWRITTEN;
        end else begin
          r.ta = q.a;
          r.node = mesh[q.a];
        end
        pending_q = {pending_q, r};
      end
      FN_CLEAR: begin
        nodes_used = 0;
        pending_q = {pending_q, r};
      end
      default: begin
        if (q.a >= nodes_used || q.b >= nodes_used || q.c >= nodes_used) begin
          push_tri(ST_UNWRITTEN, q.a, q.b, q.c, 0, 1);
        end else if (!needs_split(q.a, q.b, q.c) || by_wall(q.a) || by_wall(q.b) ||
                     by_wall(q.c)) begin
          push_tri(ST_OK, q.a, q.b, q.c, 0, 1);
        end else if (nodes_used + 3 > NODES) begin
          push_tri(ST_FULL, q.a, q.b, q.c, 0, 1);
        end else begin
          ab = nodes_used;
          bc = nodes_used + 1;
          ca = nodes_used + 2;
          mesh[ab] = midpoint(mesh[q.a], mesh[q.b]);
          mesh[bc] = midpoint(mesh[q.b], mesh[q.c]);
          mesh[ca] = midpoint(mesh[q.c], mesh[q.a]);
          nodes_used += 3;
          push_tri(ST_OK, q.a, ab, ca, 1, 0);
          push_tri(ST_OK, q.b, bc, ab, 1, 0);
          push_tri(ST_OK, q.c, ca, bc, 1, 0);
          push_tri(ST_OK, ab, bc, ca, 1, 1);
        end
      end
    endcase
  endfunction

  function automatic node_t mk_node(int px, int py, int pz, int vx, int vy, int vz);
    node_t n;
    n.pos.x = CW'(px);
    n.pos.y = CW'(py);
    n.pos.z = CW'(pz);
    n.vel.x = CW'(vx);
    n.vel.y = CW'(vy);
    n.vel.z = CW'(vz);
    return n;
  endfunction

  function automatic req_t mk_req(func_e fn, int a, int b, int c, node_t nd);
    req_t q;
    q.fn = fn;
    q.a = IDX_W'(a);
    q.b = IDX_W'(b);
    q.c = IDX_W'(c);
    q.nd = nd;
    q.typed = 1'b0;
    q.want = '0;
    return q;
  endfunction

  function automatic req_t mk_typed(func_e fn, int a, int b, int c, node_t nd,
                                    logic [1:0] st, int ta, int tb, int tc);
    req_t q;
    q = mk_req(fn, a, b, c, nd);
    q.typed = 1'b1;
    q.want.status = st;
    q.want.ta = IDX_W'(ta);
    q.want.tb = IDX_W'(tb);
    q.want.tc = IDX_W'(tc);
    q.want.last = 1'b1;
    return q;
  endfunction

  function automatic int rnd_crd(int r);
    return int'($urandom_range(0, 2 * r)) - r;
  endfunction

  function automatic node_t rnd_node(bit wide);
    if (wide)
      return mk_node($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    return mk_node(rnd_crd(BOX_R), rnd_crd(BOX_R), rnd_crd(BOX_R),
                   rnd_crd(BOX_R), rnd_crd(BOX_R), rnd_crd(BOX_R));
  endfunction

  function automatic int rnd_idx();
    if (nodes_used > 0 && $urandom_range(0, 9) != 0)
      return int'($urandom_range(0, nodes_used - 1));
    return int'($urandom_range(0, NODES - 1));
  endfunction

  function automatic req_t rnd_req();
    int pick;
    node_t nul;
    nul = '0;
    pick = $urandom_range(0, 99);
    if (pick < 35 || nodes_used < 3)
      return mk_req(FN_APPEND, $urandom, $urandom, $urandom, rnd_node($urandom_range(0, 6) == 0));
    if (pick < 80)
      return mk_req(FN_REFINE, rnd_idx(), rnd_idx(), rnd_idx(), rnd_node(1));
    if (pick < 97)
      return mk_req(FN_READ, rnd_idx(), $urandom, $urandom, rnd_node(1));
    return mk_req(FN_CLEAR, $urandom, $urandom, $urandom, nul);
  endfunction

  task automatic issue(req_t q);
    int gap;
    in_ch.valid    <= 1'b1;
    in_ch.func     <= q.fn;
    in_ch.vertex_a <= q.a;
    in_ch.vertex_b <= q.b;
    in_ch.vertex_c <= q.c;
    in_ch.in_pos_x <= q.nd.pos.x;
    in_ch.in_pos_y <= q.nd.pos.y;
    in_ch.in_pos_z <= q.nd.pos.z;
    in_ch.in_vel_x <= q.nd.vel.x;
    in_ch.in_vel_y <= q.nd.vel.y;
    in_ch.in_vel_z <= q.nd.vel.z;
    do @(posedge clk_i); while (!in_ch.ready);
    predict_mesh(q);
    if (q.typed) begin
      void'(pending_q.pop_back());
      pending_q = {pending_q, q.want};
    end
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(30, 60) : $urandom_range(1, 12);
      gap = $urandom_range(1, 15);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic load_box(cfg_t c);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_MAX_AREA;
    cfg_data_i <= c.max_area;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_HALF_WIDTH;
    cfg_data_i <= c.half_width;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_HALF_HEIGHT;
    cfg_data_i <= c.half_height;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_HALF_DEPTH;
    cfg_data_i <= c.half_depth;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_WALL_MARGIN;
    cfg_data_i <= c.wall_margin;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    box_cfg = c;
    @(posedge clk_i);
  endtask

  task automatic random_burst(int n);
    repeat (n) issue(rnd_req());
  endtask

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // result monitor
  always @(posedge clk_i) begin
    res_t w;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_q.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        w = pending_q.pop_front();
        check_field("status", w.status, out_ch.status);
        check_field("out_tri_a", w.ta, out_ch.out_tri_a);
        check_field("out_tri_b", w.tb, out_ch.out_tri_b);
        check_field("out_tri_c", w.tc, out_ch.out_tri_c);
        check_field("was_split", w.split, out_ch.was_split);
        check_field("out_pos_x", w.node.pos.x, out_ch.out_pos_x);
        check_field("out_pos_y", w.node.pos.y, out_ch.out_pos_y);
        check_field("out_pos_z", w.node.pos.z, out_ch.out_pos_z);
        check_field("out_vel_x", w.node.vel.x, out_ch.out_vel_x);
        check_field("out_vel_y", w.node.vel.y, out_ch.out_vel_y);
        check_field("out_vel_z", w.node.vel.z, out_ch.out_vel_z);
        check_field("last", w.last, out_ch.last);
      end
    end
  end

  // receiver stall pattern
  initial begin
    int hold;
    int mode_cnt;
    int mode;
    hold = 0;
    mode_cnt = 0;
    mode = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && hold == 0) begin
        hold = 300;
        hold_req = 1'b0;
      end
      if (mode_cnt == 0) begin
        mode_cnt = $urandom_range(20, 80);
        mode = $urandom_range(0, 2);
      end
      mode_cnt--;
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if (mode == 0) begin
        out_ch.ready <= 1'b1;
      end else if (mode == 1) begin
        out_ch.ready <= $urandom_range(0, 9) < 7;
      end else begin
        out_ch.ready <= $urandom_range(0, 9) < 3;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= HOLD_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    cfg_t c;
    node_t nul;
    nul = '0;
    errors = 0;
    idle_cycles = 0;
    hold_req = 1'b0;
    burst_left = 5;
    nodes_used = 0;
    foreach (mesh[i]) mesh[i] = '0;
    box_cfg = '{RST_MAX_AREA, RST_HALF_WIDTH, RST_HALF_HEIGHT, RST_HALF_DEPTH,
                RST_WALL_MARGIN};
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_MAX_AREA;
    cfg_data_i = '0;
    in_ch.valid = 1'b0;
    in_ch.func = FN_APPEND;
    in_ch.vertex_a = '0;
    in_ch.vertex_b = '0;
    in_ch.vertex_c = '0;
    in_ch.in_pos_x = '0;
    in_ch.in_pos_y = '0;
    in_ch.in_pos_z = '0;
    in_ch.in_vel_x = '0;
    in_ch.in_vel_y = '0;
    in_ch.in_vel_z = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // directed table at reset settings
    dir_q = {dir_q, mk_typed(FN_READ, 0, 0, 0, nul, ST_UNWRITTEN, 0, 0, 0)};
    dir_q = {dir_q, mk_typed(FN_REFINE, 0, 1, 2, nul, ST_UNWRITTEN, 0, 1, 2)};
    dir_q = {dir_q, mk_typed(FN_CLEAR, 5, 6, 7, nul, ST_OK, 0, 0, 0)};
    dir_q = {dir_q, mk_typed(FN_APPEND, 0, 0, 0, mk_node(8388607, 8388607, 8388607,
             8388607, 8388607, 8388607), ST_OK, 0, 0, 0)};
    dir_q = {dir_q, mk_typed(FN_APPEND, 1023, 1023, 1023, mk_node(-8388608, -8388608,
             -8388608, -8388608, -8388608, -8388608), ST_OK, 1, 0, 0)};
    dir_q = {dir_q, mk_req(FN_READ, 0, 0, 0, nul)};
    dir_q = {dir_q, mk_req(FN_READ, 1, 0, 0, nul)};
    dir_q = {dir_q, mk_typed(FN_READ, 1023, 0, 0, nul, ST_UNWRITTEN, 0, 0, 0)};
    dir_q = {dir_q, mk_req(FN_REFINE, 0, 1, 1, nul)};
    dir_q = {dir_q, mk_typed(FN_APPEND, 0, 0, 0, mk_node(0, 0, 0, -3, 5, -1),
             ST_OK, 2, 0, 0)};
    dir_q = {dir_q, mk_typed(FN_APPEND, 0, 0, 0, mk_node(65536, 0, 0, 4, -2, 7),
             ST_OK, 3, 0, 0)};
    dir_q = {dir_q, mk_typed(FN_APPEND, 0, 0, 0, mk_node(0, 65536, 0, 1, 1, -8),
             ST_OK, 4, 0, 0)};
    dir_q = {dir_q, mk_req(FN_REFINE, 2, 3, 4, nul)};
    dir_q = {dir_q, mk_req(FN_REFINE, 2, 2, 2, nul)};
    dir_q = {dir_q, mk_req(FN_READ, 5, 0, 0, nul)};
    dir_q = {dir_q, mk_req(FN_READ, 6, 0, 0, nul)};
    dir_q = {dir_q, mk_req(FN_APPEND, 0, 0, 0, mk_node(-6553, 6553, -6553, -9, 3, 1))};
    dir_q = {dir_q, mk_req(FN_REFINE, 3, 4, 8, nul)};
    dir_q = {dir_q, mk_req(FN_REFINE, 0, 3, 4, nul)};
    dir_q = {dir_q, mk_req(FN_READ, 9, 0, 0, nul)};
    dir_q = {dir_q, mk_typed(FN_CLEAR, 0, 0, 0, nul, ST_OK, 0, 0, 0)};
    dir_q = {dir_q, mk_typed(FN_READ, 0, 0, 0, nul, ST_UNWRITTEN, 0, 0, 0)};
    foreach (dir_q[i]) issue(dir_q[i]);

    random_burst(40);
    hold_req = 1'b1;
    random_burst(30);
    drain();
    random_burst(10);

    // every triangle of nonzero area splits, walls at the far ends
    c = '{23'd0, 23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 23'd0};
    load_box(c);
    random_burst(45);

    // margin above the half extents, nothing splits
    c = '{23'd0, 23'd0, 23'd0, 23'd0, 23'h7FFFFF};
    load_box(c);
    random_burst(35);

    // largest area threshold
    c = '{23'h7FFFFF, 23'h7FFFFF, 23'd131072, 23'h7FFFFF, 23'd65536};
    load_box(c);
    random_burst(35);

    // back to reset values, small fresh mesh
    c = '{RST_MAX_AREA, RST_HALF_WIDTH, RST_HALF_HEIGHT, RST_HALF_DEPTH,
          RST_WALL_MARGIN};
    load_box(c);
    random_burst(30);
    issue(mk_req(FN_CLEAR, 0, 0, 0, nul));
    issue(mk_req(FN_APPEND, 0, 0, 0, mk_node(0, 0, 0, 1, 2, 3)));
    issue(mk_req(FN_APPEND, 0, 0, 0, mk_node(131072, 0, 0, 4, 5, 6)));
    issue(mk_req(FN_APPEND, 0, 0, 0, mk_node(0, 131072, 0, 7, 8, 9)));
    issue(mk_req(FN_REFINE, 0, 1, 2, nul));
    issue(mk_req(FN_APPEND, 0, 0, 0, rnd_node(0)));
    issue(mk_req(FN_APPEND, 0, 0, 0, rnd_node(0)));
    issue(mk_req(FN_APPEND, 0, 0, 0, rnd_node(0)));
    issue(mk_req(FN_READ, 1023, 0, 0, nul));
    issue(mk_req(FN_REFINE, 0, 1, 2, nul));
    issue(mk_req(FN_REFINE, 1021, 1022, 1023, nul));

    drain();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/atsub_pkg.sv
sv/atsub_if.sv
sv/atsub_front.sv
sv/atsub_back.sv
sv/adaptive_triangle_subdivider_core.sv
bench/tb_top.sv
